>>> rtl/mono_framebuffer_text_renderer_defines.svh
// assertion macros for the frame buffer text renderer
// no dependencies; expects clk and arst_n in the including scope
`ifndef MONO_FRAMEBUFFER_TEXT_RENDERER_DEFINES_SVH
`define MONO_FRAMEBUFFER_TEXT_RENDERER_DEFINES_SVH
`ifndef SYNTHESIS
`define MFB_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define MFB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MFB_ASSERT_IMPL(label, ante, cons)
`define MFB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/mfb_pkg.sv
// shared types, constants and helpers of the frame buffer text renderer
// no dependencies
`timescale 1ns / 1ps
package mfb_pkg;
	localparam int SCREEN_WIDTH_DEF  = 128;
	localparam int SCREEN_HEIGHT_DEF = 64;
	localparam int GLYPH_WORDS_DEF   = 1024;
	localparam int IDX_W             = 13;
	localparam int FIRST_CODE        = 32;
	localparam logic [4:0] GLYPH_WIDTH_RST  = 5'd7;
	localparam logic [5:0] GLYPH_HEIGHT_RST = 6'd10;

	typedef enum logic [2:0] {
		OP_SETC = 3'd0,
		OP_PIX  = 3'd1,
		OP_CHL  = 3'd2,
		OP_CHR  = 3'd3,
		OP_FILL = 3'd4,
		OP_LOAD = 3'd5,
		OP_READ = 3'd6,
		OP_NOP  = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		REG_GLYPH_WIDTH  = 2'd0,
		REG_GLYPH_HEIGHT = 2'd1
	} reg_idx_t;

	typedef struct packed {
		op_t               op;
		logic [7:0]        pos_x;
		logic [7:0]        pos_y;
		logic              color;
		logic [6:0]        code;
		logic [9:0]        font_addr;
		logic [15:0]       font_word;
		logic [IDX_W-1:0]  pix_idx;
		logic              pix_ok;
		logic              font_ok;
		logic [IDX_W-1:0]  rd_idx;
		logic              rd_ok;
	} cmd_t;

	typedef struct packed {
		logic       no_room;
		logic [6:0] char_echo;
		logic [7:0] read_data;
	} res_t;

	typedef struct packed {
		logic [4:0] width;
		logic [5:0] height;
	} cfg_t;

	function automatic logic [IDX_W-1:0] pix_index(logic [7:0] x, logic [7:0] y, int sw);
		return IDX_W'(x) + IDX_W'(y[7:3]) * IDX_W'(sw);
	endfunction
endpackage

>>> rtl/mono_framebuffer_text_renderer.sv
// Monochrome page-addressed frame buffer with glyph blitter, top level.
// A fill rewrites every byte of the frame memory; a character first reduces
// its glyph base modulo the glyph store depth, then fetches each glyph row and
// does a read-modify-write of the frame memory for each visible pixel. One
// request at a time. After reset the frame memory is cleared, one byte a cycle;
// full stays high.
`timescale 1ns / 1ps
`include "mono_framebuffer_text_renderer_defines.svh"
module mono_framebuffer_text_renderer #(
	parameter int SCREEN_WIDTH  = mfb_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = mfb_pkg::SCREEN_HEIGHT_DEF,
	parameter int GLYPH_WORDS   = mfb_pkg::GLYPH_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  opcode,
	input  logic [7:0]  pos_x,
	input  logic [7:0]  pos_y,
	input  logic        pixel_color,
	input  logic [6:0]  char_code,
	input  logic [9:0]  font_addr,
	input  logic [15:0] font_word,
	input  logic [9:0]  byte_addr,
	output logic        empty,
	input  logic        pop,
	output logic        no_room,
	output logic [6:0]  char_echo,
	output logic [7:0]  read_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import mfb_pkg::*;

	cmd_t cmd_in, cmd_out;
	res_t res_in, res_out;
	cfg_t cfg_q;
	logic cmd_full, cmd_empty, cmd_pop, res_full, res_push, clearing;

	assign cfg_ready = 1'b1;
	assign full      = cmd_full || clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= GLYPH_WIDTH_RST;
			cfg_q.height <= GLYPH_HEIGHT_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_GLYPH_WIDTH) cfg_q.width <= cfg_data[4:0];
			if (cfg_index == REG_GLYPH_HEIGHT) cfg_q.height <= cfg_data[5:0];
		end
	end

	mfb_front #(
		.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT), .GLYPH_WORDS(GLYPH_WORDS)
	) u_front (
		.opcode(opcode), .pos_x(pos_x), .pos_y(pos_y), .pixel_color(pixel_color),
		.char_code(char_code), .font_addr(font_addr), .font_word(font_word),
		.byte_addr(byte_addr), .cmd(cmd_in)
	);

	mfb_fifo #(.WIDTH($bits(cmd_t))) u_cmd_q (
		.clk(clk), .arst_n(arst_n), .push(push && !clearing), .din(cmd_in),
		.full(cmd_full), .pop(cmd_pop), .empty(cmd_empty), .dout(cmd_out)
	);

	mfb_back #(
		.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT), .GLYPH_WORDS(GLYPH_WORDS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .cmd_empty(cmd_empty), .cmd(cmd_out),
		.cmd_pop(cmd_pop), .res_full(res_full), .res_push(res_push), .res(res_in),
		.clearing(clearing)
	);

	mfb_fifo #(.WIDTH($bits(res_t))) u_res_q (
		.clk(clk), .arst_n(arst_n), .push(res_push), .din(res_in),
		.full(res_full), .pop(pop), .empty(empty), .dout(res_out)
	);

	assign no_room   = res_out.no_room;
	assign char_echo = res_out.char_echo;
	assign read_data = res_out.read_data;

	`MFB_ASSERT_IMPL(a_res_room, res_push, !res_full)
	`MFB_ASSERT_IMPL(a_clr_full, clearing, full)
	`MFB_ASSERT_IMPL(a_cmd_avail, cmd_pop, !cmd_empty)
	`MFB_ASSERT_NEXT(a_res_shows, res_push, !empty)
endmodule

>>> rtl/mfb_fifo.sv
// two-entry queue used between front and back and for results
// no dependencies
`timescale 1ns / 1ps
module mfb_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] dout
);
	logic [WIDTH-1:0] mem_q [2];
	logic [1:0] cnt_q;
	logic wr_q, rd_q, do_push, do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end
endmodule

>>> rtl/mfb_front.sv
// front decode: classifies a request and precomputes addresses and range checks
// depends on mfb_pkg
`timescale 1ns / 1ps
module mfb_front #(
	parameter int SCREEN_WIDTH  = mfb_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = mfb_pkg::SCREEN_HEIGHT_DEF,
	parameter int GLYPH_WORDS   = mfb_pkg::GLYPH_WORDS_DEF
) (
	input  logic [2:0]    opcode,
	input  logic [7:0]    pos_x,
	input  logic [7:0]    pos_y,
	input  logic          pixel_color,
	input  logic [6:0]    char_code,
	input  logic [9:0]    font_addr,
	input  logic [15:0]   font_word,
	input  logic [9:0]    byte_addr,
	output mfb_pkg::cmd_t cmd
);
	import mfb_pkg::*;
	localparam int FRAME_BYTES = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8);

	always_comb begin
		cmd.op        = op_t'(opcode);
		cmd.pos_x     = pos_x;
		cmd.pos_y     = pos_y;
		cmd.color     = pixel_color;
		cmd.code      = char_code;
		cmd.font_addr = font_addr;
		cmd.font_word = font_word;
		cmd.pix_idx   = pix_index(pos_x, pos_y, SCREEN_WIDTH);
		cmd.pix_ok    = (pos_x < 8'(SCREEN_WIDTH)) && (pos_y < 8'(SCREEN_HEIGHT));
		cmd.font_ok   = IDX_W'(font_addr) < IDX_W'(GLYPH_WORDS);
		cmd.rd_idx    = IDX_W'(byte_addr);
		cmd.rd_ok     = IDX_W'(byte_addr) < IDX_W'(FRAME_BYTES);
	end
endmodule

>>> rtl/mfb_back.sv
// back end: frame and glyph memories, cursor, and the drawing sequencer
// depends on mfb_pkg
`timescale 1ns / 1ps
module mfb_back #(
	parameter int SCREEN_WIDTH  = mfb_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = mfb_pkg::SCREEN_HEIGHT_DEF,
	parameter int GLYPH_WORDS   = mfb_pkg::GLYPH_WORDS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mfb_pkg::cfg_t cfg,
	input  logic          cmd_empty,
	input  mfb_pkg::cmd_t cmd,
	output logic          cmd_pop,
	input  logic          res_full,
	output logic          res_push,
	output mfb_pkg::res_t res,
	output logic          clearing
);
	import mfb_pkg::*;
	localparam int FRAME_BYTES = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8);
	localparam int FB_AW = $clog2(FRAME_BYTES);
	localparam int GA_W  = $clog2(GLYPH_WORDS);

	typedef enum logic [2:0] {
		S_CLR, S_IDLE, S_PWR, S_RDW, S_MOD, S_ROW, S_COL, S_RES
	} state_t;

	state_t state_q;
	logic [7:0]  fb_mem [FRAME_BYTES];
	logic [15:0] gl_mem [GLYPH_WORDS];
	logic [7:0]  fb_rdata_q;
	logic [15:0] gword_q;
	logic [7:0]  cursor_col_q, cursor_row_q;
	logic [IDX_W-1:0] cnt_q, paddr_q, base_q;
	logic [7:0]  fill_val_q;
	logic        fill_q, glyph_q, left_q, color_q, pval_q;
	logic [2:0]  pbit_q;
	logic [4:0]  c_q;
	logic [5:0]  r_q;
	logic [6:0]  code_q;
	res_t        res_q;

	logic             fb_re, fb_we, gl_re;
	logic [FB_AW-1:0] fb_raddr, fb_waddr;
	logic [7:0]       fb_wdata;
	logic [7:0]       x, y;
	logic             on, vis;
	logic [IDX_W-1:0] cidx;
	logic [8:0]       room_x, room_y;
	logic [6:0]       gidx;

	assign x      = cursor_col_q + 8'(c_q);
	assign y      = cursor_row_q + 8'(r_q);
	assign on     = !c_q[4] && gword_q[4'd15 - c_q[3:0]];
	assign vis    = (x < 8'(SCREEN_WIDTH)) && (y < 8'(SCREEN_HEIGHT));
	assign cidx   = pix_index(x, y, SCREEN_WIDTH);
	assign room_x = 9'(cursor_col_q) + 9'(cfg.width);
	assign room_y = 9'(cursor_row_q) + 9'(cfg.height);
	// glyph index wraps at 7 bits
	assign gidx   = cmd.code - 7'(FIRST_CODE);

	assign cmd_pop  = (state_q == S_IDLE) && !cmd_empty;
	assign res_push = (state_q == S_RES) && !res_full;
	assign res      = res_q;
	assign clearing = (state_q == S_CLR) && !fill_q;

	always_comb begin
		fb_re    = 1'b0;
		fb_raddr = cmd.pix_idx[FB_AW-1:0];
		if (state_q == S_IDLE && !cmd_empty) begin
			fb_re    = (cmd.op == OP_PIX && cmd.pix_ok) || (cmd.op == OP_READ && cmd.rd_ok);
			fb_raddr = (cmd.op == OP_READ) ? cmd.rd_idx[FB_AW-1:0] : cmd.pix_idx[FB_AW-1:0];
		end else if (state_q == S_COL) begin
			fb_re    = (c_q != cfg.width) && vis;
			fb_raddr = cidx[FB_AW-1:0];
		end
		fb_we    = (state_q == S_CLR) || (state_q == S_PWR);
		fb_waddr = (state_q == S_CLR) ? cnt_q[FB_AW-1:0] : paddr_q[FB_AW-1:0];
		if (state_q == S_CLR) fb_wdata = fill_val_q;
		else if (pval_q) fb_wdata = fb_rdata_q | (8'd1 << pbit_q);
		else fb_wdata = fb_rdata_q & ~(8'd1 << pbit_q);
		gl_re = (state_q == S_ROW) && (r_q != cfg.height);
	end

	always_ff @(posedge clk) begin
		if (fb_we) fb_mem[fb_waddr] <= fb_wdata;
		if (fb_re) fb_rdata_q <= fb_mem[fb_raddr];
		if (cmd_pop && cmd.op == OP_LOAD && cmd.font_ok)
			gl_mem[cmd.font_addr[GA_W-1:0]] <= cmd.font_word;
		if (gl_re) gword_q <= gl_mem[base_q[GA_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			cnt_q        <= '0;
			fill_q       <= 1'b0;
			fill_val_q   <= 8'h00;
			cursor_col_q <= 8'd0;
			cursor_row_q <= 8'd0;
			glyph_q      <= 1'b0;
			left_q       <= 1'b0;
			color_q      <= 1'b0;
			pval_q       <= 1'b0;
			pbit_q       <= 3'd0;
			paddr_q      <= '0;
			base_q       <= '0;
			c_q          <= 5'd0;
			r_q          <= 6'd0;
			code_q       <= 7'd0;
			res_q        <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == IDX_W'(FRAME_BYTES - 1)) begin
						state_q <= fill_q ? S_RES : S_IDLE;
					end
				end
				S_IDLE: begin
					if (!cmd_empty) begin
						res_q   <= '0;
						glyph_q <= 1'b0;
						color_q <= cmd.color;
						code_q  <= cmd.code;
						base_q  <= IDX_W'(gidx) * IDX_W'(cfg.height);
						case (cmd.op)
							OP_SETC: begin
								cursor_col_q <= cmd.pos_x;
								cursor_row_q <= cmd.pos_y;
								state_q <= S_RES;
							end
							OP_PIX: begin
								paddr_q <= cmd.pix_idx;
								pbit_q  <= cmd.pos_y[2:0];
								pval_q  <= cmd.color;
								state_q <= cmd.pix_ok ? S_PWR : S_RES;
							end
							OP_CHL: begin
								left_q <= 1'b1;
								if (room_x >= 9'(SCREEN_WIDTH) || room_y >= 9'(SCREEN_HEIGHT)) begin
									res_q.no_room <= 1'b1;
									state_q <= S_RES;
								end else begin
									state_q <= S_MOD;
								end
							end
							OP_CHR: begin
								left_q <= 1'b0;
								cursor_col_q <= cursor_col_q - 8'(cfg.width);
								state_q <= S_MOD;
							end
							OP_FILL: begin
								fill_q     <= 1'b1;
								fill_val_q <= {8{cmd.color}};
								cnt_q      <= '0;
								state_q    <= S_CLR;
							end
							OP_READ: state_q <= cmd.rd_ok ? S_RDW : S_RES;
							default: state_q <= S_RES;
						endcase
					end
				end
				S_RDW: begin
					res_q.read_data <= fb_rdata_q;
					state_q <= S_RES;
				end
				S_PWR: state_q <= glyph_q ? S_COL : S_RES;
				S_MOD: begin
					// reduce glyph base address modulo the store depth
					if (base_q >= IDX_W'(GLYPH_WORDS)) begin
						base_q <= base_q - IDX_W'(GLYPH_WORDS);
					end else begin
						r_q <= 6'd0;
						state_q <= S_ROW;
					end
				end
				S_ROW: begin
					c_q <= 5'd0;
					if (r_q == cfg.height) begin
						if (left_q) cursor_col_q <= cursor_col_q + 8'(cfg.width);
						res_q.char_echo <= code_q;
						state_q <= S_RES;
					end else begin
						state_q <= S_COL;
					end
				end
				S_COL: begin
					if (c_q == cfg.width) begin
						r_q <= r_q + 6'd1;
						base_q <= (base_q == IDX_W'(GLYPH_WORDS - 1)) ? '0 : base_q + 1'b1;
						state_q <= S_ROW;
					end else begin
						c_q <= c_q + 5'd1;
						if (vis) begin
							paddr_q <= cidx;
							pbit_q  <= y[2:0];
							pval_q  <= on ? color_q : !color_q;
							glyph_q <= 1'b1;
							state_q <= S_PWR;
						end
					end
				end
				S_RES: begin
					if (!res_full) begin
						fill_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> test/tb_mono_framebuffer_text_renderer.sv
// self-checking testbench for the mono frame buffer text renderer
// depends on mfb_pkg and mono_framebuffer_text_renderer; predicts every result in place
`timescale 1ns / 1ps
module tb_mono_framebuffer_text_renderer;
	import mfb_pkg::*;

	localparam int SW = 128;
	localparam int SH = 64;
	localparam int GW = 1024;
	localparam int FB_BYTES = SW * ((SH + 7) / 8);
	localparam int STALL_LIMIT = 20000;
	// font rows loaded up front; characters only touch these
	localparam int FONT_ROWS = 384;

	typedef struct {
		op_t         op;
		logic [7:0]  x;
		logic [7:0]  y;
		logic        color;
		logic [6:0]  code;
		logic [9:0]  faddr;
		logic [15:0] fword;
		logic [9:0]  baddr;
	} render_cmd_t;

	logic clk, arst_n;
	logic push, full, empty, pop;
	logic [2:0] opcode;
	logic [7:0] pos_x, pos_y;
	logic pixel_color;
	logic [6:0] char_code;
	logic [9:0] font_addr, byte_addr;
	logic [15:0] font_word;
	logic no_room;
	logic [6:0] char_echo;
	logic [7:0] read_data;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	// shadow of the block state
	logic [7:0]  frame_mirror [0:FB_BYTES-1];
	logic [15:0] font_mirror [0:GW-1];
	logic [7:0]  cur_col, cur_row;
	int          glyph_w, glyph_h;

	res_t pending_results[$];
	int   errors;
	int   send_idle_pct, recv_idle_pct;
	int   pop_hold;
	int   quiet_cycles;

	mono_framebuffer_text_renderer u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .opcode(opcode),
		.pos_x(pos_x), .pos_y(pos_y), .pixel_color(pixel_color), .char_code(char_code),
		.font_addr(font_addr), .font_word(font_word), .byte_addr(byte_addr),
		.empty(empty), .pop(pop), .no_room(no_room), .char_echo(char_echo),
		.read_data(read_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void plot(input int x, input int y, input logic white);
		int idx;
		if (x >= SW || y >= SH) return;
		idx = x + (y / 8) * SW;
		frame_mirror[idx][y % 8] = white;
	endfunction

	function automatic void blit_glyph(input logic [6:0] code, input logic color);
		int gidx, addr;
		logic [15:0] word;
		logic on;
		gidx = (int'(code) - FIRST_CODE) & 8'h7f;
		for (int r = 0; r < glyph_h; r++) begin
			addr = (gidx * glyph_h + r) % GW;
			word = font_mirror[addr];
			for (int c = 0; c < glyph_w; c++) begin
				on = (c < 16) ? word[15 - c] : 1'b0;
				plot((int'(cur_col) + c) & 8'hff, (int'(cur_row) + r) & 8'hff,
					on ? color : ~color);
			end
		end
	endfunction

	function automatic void render_model(input render_cmd_t cmd, output res_t res);
		res = '0;
		case (cmd.op)
			OP_SETC: begin
				cur_col = cmd.x;
				cur_row = cmd.y;
			end
			OP_PIX: plot(cmd.x, cmd.y, cmd.color);
			OP_CHL: begin
				if (SW <= int'(cur_col) + glyph_w || SH <= int'(cur_row) + glyph_h) begin
					res.no_room = 1'b1;
				end else begin
					blit_glyph(cmd.code, cmd.color);
					cur_col = cur_col + 8'(glyph_w);
					res.char_echo = cmd.code;
				end
			end
			OP_CHR: begin
				cur_col = cur_col - 8'(glyph_w);
				blit_glyph(cmd.code, cmd.color);
				res.char_echo = cmd.code;
			end
			OP_FILL: for (int i = 0; i < FB_BYTES; i++) frame_mirror[i] = {8{cmd.color}};
			OP_LOAD: if (cmd.faddr < GW) font_mirror[cmd.faddr] = cmd.fword;
			OP_READ: if (cmd.baddr < FB_BYTES) res.read_data = frame_mirror[cmd.baddr];
			default: ;
		endcase
	endfunction

	task automatic send_request(input render_cmd_t cmd);
		res_t res;
		int gap;
		gap = 0;
		if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 6);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		opcode <= cmd.op;
		pos_x <= cmd.x;
		pos_y <= cmd.y;
		pixel_color <= cmd.color;
		char_code <= cmd.code;
		font_addr <= cmd.faddr;
		font_word <= cmd.fword;
		byte_addr <= cmd.baddr;
		do @(posedge clk); while (full);
		render_model(cmd, res);
		pending_results.push_back(res);
	endtask

	function automatic render_cmd_t rand_fields(input op_t op);
		render_cmd_t c;
		c.op = op;
		c.x = $urandom_range(3) == 0 ? 8'($urandom_range(255)) : 8'($urandom_range(SW - 1));
		c.y = $urandom_range(3) == 0 ? 8'($urandom_range(255)) : 8'($urandom_range(SH - 1));
		c.color = 1'($urandom_range(1));
		c.code = $urandom_range(7) == 0 ? 7'($urandom_range(127)) : 7'($urandom_range(32, 127));
		c.faddr = 10'($urandom_range(GW - 1));
		c.fword = 16'($urandom_range(16'hffff));
		c.baddr = 10'($urandom_range(FB_BYTES - 1));
		return c;
	endfunction

	// a character code whose glyph rows all lie in the loaded part of the font
	function automatic logic [6:0] pick_code();
		logic [6:0] code;
		int gidx;
		logic ok;
		for (int t = 0; t < 64; t++) begin
			code = $urandom_range(7) == 0 ? 7'($urandom_range(127)) :
				7'($urandom_range(32, 127));
			gidx = (int'(code) - FIRST_CODE) & 8'h7f;
			ok = 1'b1;
			for (int r = 0; r < glyph_h; r++)
				if ((gidx * glyph_h + r) % GW >= FONT_ROWS) ok = 1'b0;
			if (ok) return code;
		end
		return 7'(FIRST_CODE);
	endfunction

	function automatic render_cmd_t rand_char(input op_t op);
		render_cmd_t c;
		c = rand_fields(op);
		c.code = pick_code();
		return c;
	endfunction

	task automatic send_op(input op_t op, input int x = 0, input int y = 0,
		input logic color = 1'b1, input int code = 65, input int baddr = 0);
		render_cmd_t c;
		c = rand_fields(op);
		c.x = 8'(x);
		c.y = 8'(y);
		c.color = color;
		c.code = 7'(code);
		c.baddr = 10'(baddr);
		send_request(c);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		// a fill returns its result only after the whole frame is written
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input int value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 8'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_GLYPH_WIDTH) glyph_w = value & 5'h1f;
		else glyph_h = value & 6'h3f;
	endtask

	// every font row a character can reach is written before any is drawn
	task automatic test_font_load();
		render_cmd_t c;
		for (int a = 0; a < FONT_ROWS; a++) begin
			c = rand_fields(OP_LOAD);
			c.faddr = 10'(a);
			if (a == 0) c.fword = 16'hffff;
			if (a == 1) c.fword = 16'h0000;
			send_request(c);
		end
	endtask

	task automatic test_directed();
		send_op(OP_PIX, 0, 0, 1'b1);
		send_op(OP_PIX, SW - 1, SH - 1, 1'b1);
		send_op(OP_PIX, SW, 0, 1'b1);
		send_op(OP_PIX, 0, SH, 1'b1);
		send_op(OP_PIX, 255, 255, 1'b1);
		send_op(OP_READ, 0, 0, 1'b0, 32, 0);
		send_op(OP_READ, 0, 0, 1'b0, 32, FB_BYTES - 1);
		send_op(OP_SETC, 0, 0);
		send_op(OP_CHL, 0, 0, 1'b1, 32);
		send_op(OP_CHL, 0, 0, 1'b0, 33);
		send_op(OP_SETC, SW - 7, 0);
		// no room at the right edge
		send_op(OP_CHL, 0, 0, 1'b1, 65);
		send_op(OP_SETC, 0, SH - 10);
		send_op(OP_CHL, 0, 0, 1'b1, 65);
		// right aligned from near the left edge wraps the cursor
		send_op(OP_SETC, 3, 20);
		send_op(OP_CHR, 0, 0, 1'b1, 66);
		send_op(OP_SETC, 50, 60);
		send_op(OP_CHR, 0, 0, 1'b0, 67);
		send_op(OP_READ, 0, 0, 1'b0, 32, 7 * SW + 45);
		send_op(OP_FILL, 0, 0, 1'b1);
		send_op(OP_READ, 0, 0, 1'b0, 32, 513);
		send_op(OP_FILL, 0, 0, 1'b0);
		send_op(OP_NOP, 255, 255, 1'b1, 127, 1023);
		send_op(OP_READ, 0, 0, 1'b0, 32, 200);
	endtask

	// cursor-then-text runs, mixed with pixel, read and other traffic
	task automatic test_random(input int count, input int fill_pct);
		render_cmd_t c;
		int k, pick;
		k = 0;
		while (k < count) begin
			pick = $urandom_range(99);
			if (pick < 20) begin
				c = rand_fields(OP_SETC);
				if ($urandom_range(3) != 0) begin
					c.x = 8'($urandom_range(SW - 1));
					c.y = 8'($urandom_range(SH - 1));
				end
				send_request(c);
				for (int j = $urandom_range(1, 4); j > 0; j--) begin
					send_request(rand_char($urandom_range(1) ? OP_CHL : OP_CHR));
					k++;
				end
			end else if (pick < 45) send_request(rand_fields(OP_PIX));
			else if (pick < 70) send_request(rand_fields(OP_READ));
			else if (pick < 80) send_request(rand_fields(OP_LOAD));
			else if (pick < 85) send_request(rand_fields(OP_NOP));
			else if (pick < 85 + fill_pct) send_request(rand_fields(OP_FILL));
			else send_request(rand_char($urandom_range(1) ? OP_CHL : OP_CHR));
			k++;
		end
	endtask

	task automatic test_backpressure();
		wait_drained();
		pop_hold = 400;
		test_random(30, 0);
		// wait for every result before going on
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (pop_hold > 0) begin
			pop_hold <= pop_hold - 1;
			pop <= 1'b0;
		end else begin
			pop <= $urandom_range(99) >= recv_idle_pct;
		end
	end

	always @(posedge clk) begin
		res_t exp_res;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with no request pending: %0d %0d %0d",
					$time, no_room, char_echo, read_data);
				errors++;
			end else begin
				exp_res = pending_results.pop_front();
				if (no_room !== exp_res.no_room) begin
					$display("%0t: no_room expected %0d actual %0d",
						$time, exp_res.no_room, no_room);
					errors++;
				end
				if (char_echo !== exp_res.char_echo) begin
					$display("%0t: char_echo expected %0d actual %0d",
						$time, exp_res.char_echo, char_echo);
					errors++;
				end
				if (read_data !== exp_res.read_data) begin
					$display("%0t: read_data expected %0h actual %0h",
						$time, exp_res.read_data, read_data);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		opcode = OP_NOP;
		pos_x = '0;
		pos_y = '0;
		pixel_color = 1'b0;
		char_code = '0;
		font_addr = '0;
		font_word = '0;
		byte_addr = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_GLYPH_WIDTH;
		cfg_data = '0;
		errors = 0;
		pop_hold = 0;
		quiet_cycles = 0;
		send_idle_pct = 28;
		recv_idle_pct = 52;
		for (int i = 0; i < FB_BYTES; i++) frame_mirror[i] = '0;
		for (int i = 0; i < GW; i++) font_mirror[i] = '0;
		cur_col = '0;
		cur_row = '0;
		glyph_w = GLYPH_WIDTH_RST;
		glyph_h = GLYPH_HEIGHT_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_font_load();
		test_directed();
		test_random(100, 3);
		test_backpressure();

		send_idle_pct = 52;
		recv_idle_pct = 28;
		write_reg(REG_GLYPH_WIDTH, 1);
		write_reg(REG_GLYPH_HEIGHT, 1);
		test_random(100, 3);
		write_reg(REG_GLYPH_WIDTH, 16);
		write_reg(REG_GLYPH_HEIGHT, 32);
		test_random(40, 0);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_GLYPH_WIDTH, $urandom_range(1, 16));
		write_reg(REG_GLYPH_HEIGHT, $urandom_range(1, 12));
		test_random(80, 2);
		write_reg(REG_GLYPH_WIDTH, 5);
		write_reg(REG_GLYPH_HEIGHT, 8);
		test_random(80, 2);

		wait_drained();
		repeat (50) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
